// ----- hdl/fwrbv_pkg.sv -----
package fwrbv_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_W  = 5;

   typedef enum logic [1:0] {
      REQ_ENQUEUE = 2'd0,
      REQ_DEQUEUE = 2'd1,
      REQ_DELETE  = 2'd2,
      REQ_NOP     = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

// ----- hdl/fwrbv_cell.sv -----
module fwrbv_cell (
   input  logic                                    clock,
   input  fwrbv_pkg::cell_ctl_type                 ctl,
   input  logic signed [fwrbv_pkg::DATA_W-1:0]     tail_value,
   input  logic signed [fwrbv_pkg::DATA_W-1:0]     next_value,
   input  logic signed [fwrbv_pkg::DATA_W-1:0]     key,
   output logic signed [fwrbv_pkg::DATA_W-1:0]     data,
   output logic                                    match
);

   logic signed [fwrbv_pkg::DATA_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      priority if (ctl.load) begin
         data_ff <= tail_value;
      end else if (ctl.shift) begin
         data_ff <= next_value;
      end else begin
         data_ff <= data_ff;
      end
   end

   assign data  = data_ff;
   assign match = (data_ff == key);

endmodule

// ----- hdl/fwrbv_ctrl.sv -----
module fwrbv_ctrl (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [1:0]                              req_type,
   input  logic signed [fwrbv_pkg::DATA_W-1:0]     req_value,
   input  logic [fwrbv_pkg::DEPTH-1:0]             match,
   input  logic signed [fwrbv_pkg::DATA_W-1:0]     head_value,
   output fwrbv_pkg::cell_ctl_type                 ctl [fwrbv_pkg::DEPTH],
   output logic signed [fwrbv_pkg::DATA_W-1:0]     key,
   output logic [fwrbv_pkg::CNT_W-1:0]             count,
   output logic                                    rsp_strobe,
   output logic [1:0]                              rsp_status,
   output logic signed [fwrbv_pkg::DATA_W-1:0]     rsp_out_value,
   output logic [fwrbv_pkg::OCC_W-1:0]             rsp_occupancy
);

   fwrbv_pkg::state_type                  state_ff, state_in;
   logic [fwrbv_pkg::CNT_W-1:0]           count_ff, count_in;
   logic [fwrbv_pkg::CNT_W-1:0]           ptr_ff, ptr_in;
   logic                                  found_ff, found_in;
   logic signed [fwrbv_pkg::DATA_W-1:0]   key_ff, key_in;
   logic                                  strobe_ff, strobe_in;
   fwrbv_pkg::status_type                 status_ff, status_in;
   logic signed [fwrbv_pkg::DATA_W-1:0]   value_ff, value_in;
   logic                                  enq_go, deq_go, scan_shift, hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fwrbv_pkg::S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      found_ff  <= found_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      value_ff  <= value_in;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      found_in   = found_ff;
      key_in     = key_ff;
      strobe_in  = 1'b0;
      status_in  = status_ff;
      value_in   = value_ff;
      enq_go     = 1'b0;
      deq_go     = 1'b0;
      scan_shift = 1'b0;
      hit        = 1'b0;
      unique case (state_ff)
         fwrbv_pkg::S_IDLE: begin
            if (start) begin
               unique case (fwrbv_pkg::req_code_type'(req_type))
                  fwrbv_pkg::REQ_ENQUEUE: begin
                     strobe_in = 1'b1;
                     value_in  = '0;
                     if (count_ff == fwrbv_pkg::CNT_W'(fwrbv_pkg::DEPTH)) begin
                        status_in = fwrbv_pkg::STAT_FULL;
                     end else begin
                        status_in = fwrbv_pkg::STAT_DONE;
                        enq_go    = 1'b1;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  fwrbv_pkg::REQ_DEQUEUE: begin
                     strobe_in = 1'b1;
                     if (count_ff == '0) begin
                        status_in = fwrbv_pkg::STAT_EMPTY;
                        value_in  = '0;
                     end else begin
                        status_in = fwrbv_pkg::STAT_DONE;
                        value_in  = head_value;
                        deq_go    = 1'b1;
                        count_in  = count_ff - 1'b1;
                     end
                  end
                  fwrbv_pkg::REQ_DELETE: begin
                     state_in = fwrbv_pkg::S_SCAN;
                     ptr_in   = '0;
                     found_in = 1'b0;
                     key_in   = req_value;
                  end
                  fwrbv_pkg::REQ_NOP: begin
                     strobe_in = 1'b1;
                     status_in = fwrbv_pkg::STAT_DONE;
                     value_in  = '0;
                  end
               endcase
            end
         end
         fwrbv_pkg::S_SCAN: begin
            if (ptr_ff == count_ff) begin
               state_in  = fwrbv_pkg::S_IDLE;
               strobe_in = 1'b1;
               value_in  = '0;
               if (found_ff) begin
                  status_in = fwrbv_pkg::STAT_DONE;
                  count_in  = count_ff - 1'b1;
               end else begin
                  status_in = fwrbv_pkg::STAT_NOT_FOUND;
               end
            end else begin
               hit        = found_ff | match[ptr_ff[fwrbv_pkg::IDX_W-1:0]];
               scan_shift = hit;
               found_in   = hit;
               ptr_in     = ptr_ff + 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < fwrbv_pkg::DEPTH; i++) begin
         ctl[i].load  = enq_go && (count_ff == fwrbv_pkg::CNT_W'(i));
         ctl[i].shift = deq_go || (scan_shift && (ptr_ff == fwrbv_pkg::CNT_W'(i)));
      end
   end

   assign busy          = (state_ff != fwrbv_pkg::S_IDLE);
   assign key           = key_ff;
   assign count         = count_ff;
   assign rsp_strobe    = strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_value = value_ff;
   assign rsp_occupancy = fwrbv_pkg::OCC_W'(count_ff);

endmodule

// ----- hdl/fifo_with_remove_by_value.sv -----
// Enqueue, dequeue and unused requests give their result word in the cycle after start,
// and a new request may be started in every cycle for them.
// A delete walks the cells one per cycle, with busy high meanwhile; its result word is
// registered once the walk over the chain of cells reaches the entry count.
// Synchronous reset empties the queue; the cell contents are not cleared.
// The receiver cannot stall: each result word is shown for one cycle only.
module fifo_with_remove_by_value (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [1:0]                              req_type,
   input  logic signed [fwrbv_pkg::DATA_W-1:0]     req_value,
   output logic                                    rsp_strobe,
   output logic [1:0]                              rsp_status,
   output logic signed [fwrbv_pkg::DATA_W-1:0]     rsp_out_value,
   output logic [fwrbv_pkg::OCC_W-1:0]             rsp_occupancy
);

   fwrbv_pkg::cell_ctl_type               ctl [fwrbv_pkg::DEPTH];
   logic signed [fwrbv_pkg::DATA_W-1:0]   data [fwrbv_pkg::DEPTH];
   logic signed [fwrbv_pkg::DATA_W-1:0]   data_next [fwrbv_pkg::DEPTH];
   logic [fwrbv_pkg::DEPTH-1:0]           match;
   logic signed [fwrbv_pkg::DATA_W-1:0]   key;
   logic [fwrbv_pkg::CNT_W-1:0]           count;

   fwrbv_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_value     (req_value),
      .match         (match),
      .head_value    (data[0]),
      .ctl           (ctl),
      .key           (key),
      .count         (count),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_out_value (rsp_out_value),
      .rsp_occupancy (rsp_occupancy)
   );

   for (genvar i = 0; i < fwrbv_pkg::DEPTH; i++) begin : g_cell
      if (i < fwrbv_pkg::DEPTH - 1) begin : g_mid
         assign data_next[i] = data[i + 1];
      end else begin : g_last
         assign data_next[i] = data[i];
      end

      fwrbv_cell u_cell (
         .clock      (clock),
         .ctl        (ctl[i]),
         .tail_value (req_value),
         .next_value (data_next[i]),
         .key        (key),
         .data       (data[i]),
         .match      (match[i])
      );
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= fwrbv_pkg::CNT_W'(fwrbv_pkg::DEPTH))
      else $error("Entry count exceeds the queue depth.");

   a_quick_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type != fwrbv_pkg::REQ_DELETE)) |=> rsp_strobe)
      else $error("A non-delete request did not give its result word next cycle.");

   a_failed_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != fwrbv_pkg::STAT_DONE)) |-> $stable(count))
      else $error("A failed request changed the entry count.");

   a_delete_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == fwrbv_pkg::REQ_DELETE)) |=> (busy && !rsp_strobe))
      else $error("A delete request did not enter its scan.");

endmodule

// ----- dv/fifo_with_remove_by_value_test.sv -----
module fifo_with_remove_by_value_test;
   import fwrbv_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM    = 1200;
   localparam int BLOCK_LEN   = 40;

   typedef struct {
      req_code_type             code;
      logic signed [DATA_W-1:0] value;
   } req_word_type;

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] out_value;
      logic [OCC_W-1:0]         occupancy;
   } rsp_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_type = REQ_NOP;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_strobe;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_out_value;
   logic [OCC_W-1:0]         rsp_occupancy;

   req_word_type             pending_reqs[$];
   rsp_word_type             expected_rsps[$];
   logic signed [DATA_W-1:0] held_words[$];
   logic signed [DATA_W-1:0] value_pool[8];
   req_word_type             driven_word;
   int                       total_words = 0;
   int                       n_accepted = 0;
   int                       n_mismatches = 0;
   int                       n_cycles = 0;

   fifo_with_remove_by_value dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_out_value (rsp_out_value),
      .rsp_occupancy (rsp_occupancy)
   );

   always #2 clock = ~clock;

   // Works out the result word of one request and updates the held entries.
   function automatic rsp_word_type queue_predict(req_word_type w);
      rsp_word_type r;
      int           hit;
      r.status = STAT_DONE;
      r.out_value = '0;
      hit = -1;
      case (w.code)
         REQ_ENQUEUE: begin
            if (held_words.size() >= DEPTH)
               r.status = STAT_FULL;
            else
               held_words.push_back(w.value);
         end
         REQ_DEQUEUE: begin
            if (held_words.size() == 0)
               r.status = STAT_EMPTY;
            else
               r.out_value = held_words.pop_front();
         end
         REQ_DELETE: begin
            r.status = STAT_NOT_FOUND;
            foreach (held_words[i])
               if (hit < 0 && held_words[i] == w.value)
                  hit = i;
            if (hit >= 0) begin
               held_words.delete(hit);
               r.status = STAT_DONE;
            end
         end
         default: ;
      endcase
      r.occupancy = OCC_W'(held_words.size());
      return r;
   endfunction

   function automatic int sender_idle_pct();
      if (n_accepted < total_words / 3)
         return 34;
      else if (n_accepted < (2 * total_words) / 3)
         return 50;
      return 0;
   endfunction

   task automatic add_word(req_code_type code, logic signed [DATA_W-1:0] value);
      req_word_type w;
      w.code = code;
      w.value = value;
      pending_reqs.push_back(w);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value(int pool_pct);
      if ($urandom_range(99) < pool_pct)
         return value_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   task automatic flag_error(string msg);
      n_mismatches++;
      if (n_mismatches <= 10)
         $display("%s", msg);
   endtask

   always @(posedge clock) begin : drive
      logic go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         go = start;
         if (start && !busy) begin
            expected_rsps.push_back(queue_predict(driven_word));
            n_accepted++;
            go = 1'b0;
         end
         if (!go && pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
            driven_word = pending_reqs.pop_front();
            req_type <= driven_word.code;
            req_value <= driven_word.value;
            go = 1'b1;
         end
         start <= go;
      end
   end

   always @(posedge clock) begin : check
      rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            flag_error($sformatf("Result word with none expected: status %0d value %0d occ %0d",
                                 rsp_status, rsp_out_value, rsp_occupancy));
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_status !== want.status || rsp_out_value !== want.out_value ||
                rsp_occupancy !== want.occupancy)
               flag_error($sformatf({"Mismatch: expected status %0d value %0d occ %0d,",
                                     " got status %0d value %0d occ %0d"},
                                    want.status, want.out_value, want.occupancy,
                                    rsp_status, rsp_out_value, rsp_occupancy));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      n_cycles++;
      if (n_cycles >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", n_cycles);
         $display("fifo_with_remove_by_value_test: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int enq_bias;
      int r;
      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7FFF_FFFF;
      for (int i = 2; i < 8; i++)
         value_pool[i] = $urandom;

      // Corner cases on an empty queue, then a full one with repeated values.
      add_word(REQ_DEQUEUE, 32'sd0);
      add_word(REQ_DELETE, 32'sd7);
      add_word(REQ_NOP, -32'sd1);
      add_word(REQ_ENQUEUE, 32'sh8000_0000);
      add_word(REQ_ENQUEUE, 32'sh7FFF_FFFF);
      add_word(REQ_ENQUEUE, 32'sd0);
      add_word(REQ_ENQUEUE, -32'sd1);
      add_word(REQ_ENQUEUE, 32'sd5);
      add_word(REQ_ENQUEUE, 32'sd5);
      for (int i = 6; i < DEPTH - 1; i++)
         add_word(REQ_ENQUEUE, $urandom);
      add_word(REQ_ENQUEUE, 32'sd99);
      add_word(REQ_ENQUEUE, 32'sd123);
      add_word(REQ_DELETE, 32'sd99);
      add_word(REQ_DELETE, 32'sd42);
      add_word(REQ_DELETE, 32'sd5);
      add_word(REQ_DELETE, 32'sh8000_0000);
      add_word(REQ_DEQUEUE, 32'sh5555_5555);

      // Runs of requests lean towards filling or towards draining the queue.
      enq_bias = 60;
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % BLOCK_LEN == 0)
            enq_bias = $urandom_range(1) ? 65 : 30;
         r = $urandom_range(99);
         if (r < 5)
            add_word(REQ_NOP, $urandom);
         else if (r < 5 + enq_bias)
            add_word(REQ_ENQUEUE, pick_value(60));
         else if ($urandom_range(1))
            add_word(REQ_DEQUEUE, $urandom);
         else
            add_word(REQ_DELETE, pick_value(75));
      end
      total_words = pending_reqs.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);

      if (n_mismatches == 0 && expected_rsps.size() == 0)
         $display("fifo_with_remove_by_value_test: PASS");
      else
         $display("fifo_with_remove_by_value_test: FAIL");
      $finish;
   end
endmodule
